// ----- rtl/hsv2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared types and constants for the front end, the work queue and the
// arithmetic back end of the converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

    localparam int DEFAULT_HUE_WIDTH = 16;
    localparam int PCT_W             = 7;
    localparam int FACTOR_W          = 6;

    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Register stages in the front end between an accepted word and its push.
    localparam int FRONT_STAGES = 5;

    typedef enum logic [2:0] {
        SXT_RED_YELLOW,
        SXT_YELLOW_GREEN,
        SXT_GREEN_CYAN,
        SXT_CYAN_BLUE,
        SXT_BLUE_MAGENTA,
        SXT_MAGENTA_RED
    } t_sextant;

    typedef struct packed {
        t_sextant            sextant;
        logic [FACTOR_W-1:0] factor;
        logic [PCT_W-1:0]    sat;
        logic [PCT_W-1:0]    val;
    } t_item;

endpackage

`default_nettype wire

// ----- rtl/hsv2rgb_front.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB front end
// Clamps saturation and value, wraps the signed hue into 0..359 and
// classifies it into a sextant and a ramp factor, one word per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_front #(
    parameter int HUE_WIDTH = hsv2rgb_pkg::DEFAULT_HUE_WIDTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic [HUE_WIDTH-1:0]          i_hue,
    input  wire logic [hsv2rgb_pkg::PCT_W-1:0] i_saturation,
    input  wire logic [hsv2rgb_pkg::PCT_W-1:0] i_brightness,
    output logic                               o_push,
    output hsv2rgb_pkg::t_item                 o_item
);
    import hsv2rgb_pkg::*;

    // The offset hue is split as 8 * div + lo, and div is reduced modulo 45
    // by a reciprocal multiply with one correction step.
    localparam int DIV_W     = HUE_WIDTH - 3;
    localparam int REM_SHIFT = DIV_W + 6;
    localparam int PROD_W    = 2 * DIV_W + 1;
    localparam int Q_W       = PROD_W - REM_SHIFT;

    localparam logic [63:0]      RECIP_WIDE = ((64'd1 << REM_SHIFT) + 64'd44) / 64'd45;
    localparam logic [DIV_W:0]   RECIP      = RECIP_WIDE[DIV_W:0];
    localparam logic [DIV_W-1:0] MOD_BASE   = DIV_W'(45);

    localparam logic [63:0] BIAS_WIDE = (64'd1 << (HUE_WIDTH - 1)) % 64'd360;
    localparam logic [8:0]  HUE_BIAS  = BIAS_WIDE[8:0];
    localparam logic [8:0]  HUE_COMP  = 9'd360 - HUE_BIAS;

    localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(100);

    logic                 r_f0_vld, r_f1_vld, r_f2_vld, r_f3_vld, r_f4_vld;
    logic [DIV_W-1:0]     r_f0_div, r_f1_div;
    logic [2:0]           r_f0_lo, r_f1_lo, r_f2_lo;
    logic [PCT_W-1:0]     r_f0_sat, r_f1_sat, r_f2_sat, r_f3_sat;
    logic [PCT_W-1:0]     r_f0_val, r_f1_val, r_f2_val, r_f3_val;
    logic [PROD_W-1:0]    r_f1_prod;
    logic [5:0]           r_f2_r45;
    logic [8:0]           r_f3_hue;
    t_item                r_f4_item;

    logic [HUE_WIDTH-1:0] n_offset_hue;
    logic [Q_W-1:0]       n_quot;
    logic [DIV_W-1:0]     n_rem;
    logic [5:0]           n_r45;
    logic [8:0]           n_hue_raw;
    logic [8:0]           n_hue;
    logic [6:0]           n_hm;
    logic [5:0]           n_dist;
    t_item                n_item;

    always_comb begin
        n_offset_hue = {~i_hue[HUE_WIDTH-1], i_hue[HUE_WIDTH-2:0]};

        n_quot = r_f1_prod[PROD_W-1 -: Q_W];
        n_rem  = r_f1_div - DIV_W'(n_quot) * MOD_BASE;
        n_r45  = (n_rem >= MOD_BASE) ? 6'(n_rem - MOD_BASE) : n_rem[5:0];

        n_hue_raw = {r_f2_r45, r_f2_lo};
        n_hue     = (n_hue_raw >= HUE_BIAS) ? n_hue_raw - HUE_BIAS : n_hue_raw + HUE_COMP;

        if (r_f3_hue >= 9'd240) begin
            n_hm = 7'(r_f3_hue - 9'd240);
        end else if (r_f3_hue >= 9'd120) begin
            n_hm = 7'(r_f3_hue - 9'd120);
        end else begin
            n_hm = r_f3_hue[6:0];
        end
        n_dist = (n_hm >= 7'd60) ? 6'(n_hm - 7'd60) : 6'(7'd60 - n_hm);

        if (r_f3_hue < 9'd60) begin
            n_item.sextant = SXT_RED_YELLOW;
        end else if (r_f3_hue < 9'd120) begin
            n_item.sextant = SXT_YELLOW_GREEN;
        end else if (r_f3_hue < 9'd180) begin
            n_item.sextant = SXT_GREEN_CYAN;
        end else if (r_f3_hue < 9'd240) begin
            n_item.sextant = SXT_CYAN_BLUE;
        end else if (r_f3_hue < 9'd300) begin
            n_item.sextant = SXT_BLUE_MAGENTA;
        end else begin
            n_item.sextant = SXT_MAGENTA_RED;
        end
        n_item.factor = 6'd60 - n_dist;
        n_item.sat    = r_f3_sat;
        n_item.val    = r_f3_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f0_vld <= 1'b0;
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
            r_f3_vld <= 1'b0;
            r_f4_vld <= 1'b0;
        end else begin
            r_f0_vld <= i_accept;
            r_f1_vld <= r_f0_vld;
            r_f2_vld <= r_f1_vld;
            r_f3_vld <= r_f2_vld;
            r_f4_vld <= r_f3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f0_div  <= n_offset_hue[HUE_WIDTH-1:3];
        r_f0_lo   <= n_offset_hue[2:0];
        r_f0_sat  <= (i_saturation > PCT_MAX) ? PCT_MAX : i_saturation;
        r_f0_val  <= (i_brightness > PCT_MAX) ? PCT_MAX : i_brightness;

        r_f1_prod <= PROD_W'(r_f0_div) * PROD_W'(RECIP);
        r_f1_div  <= r_f0_div;
        r_f1_lo   <= r_f0_lo;
        r_f1_sat  <= r_f0_sat;
        r_f1_val  <= r_f0_val;

        r_f2_r45  <= n_r45;
        r_f2_lo   <= r_f1_lo;
        r_f2_sat  <= r_f1_sat;
        r_f2_val  <= r_f1_val;

        r_f3_hue  <= n_hue;
        r_f3_sat  <= r_f2_sat;
        r_f3_val  <= r_f2_val;

        r_f4_item <= n_item;
    end

    assign o_push = r_f4_vld;
    assign o_item = r_f4_item;

    a_hue_wrapped : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f3_vld |-> (r_f3_hue < 9'd360))
        else $error("wrapped hue out of range");

    a_item_bounds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f4_vld |-> (r_f4_item.factor <= 6'd60 && r_f4_item.sat <= PCT_MAX
                      && r_f4_item.val <= PCT_MAX))
        else $error("classified word out of range");

endmodule

`default_nettype wire

// ----- rtl/hsv2rgb_queue.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB work queue
// Short FIFO between the front end and the back end. The back end takes
// the head word in every cycle in which the queue holds one.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_queue (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_push,
    input  hsv2rgb_pkg::t_item                       i_item,
    output logic                                     o_vld,
    output hsv2rgb_pkg::t_item                       o_item,
    output logic [hsv2rgb_pkg::QUEUE_CNT_W-1:0]      o_level
);
    import hsv2rgb_pkg::*;

    t_item                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    t_item                  r_head;
    logic                   r_head_vld;
    logic                   n_pop;

    assign n_pop = (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
            r_head_vld <= 1'b0;
        end else begin
            r_head_vld <= n_pop;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (n_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !n_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && n_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
        if (n_pop) begin
            r_head <= r_mem[r_rd_ptr];
        end
    end

    assign o_vld   = r_head_vld;
    assign o_item  = r_head;
    assign o_level = r_count;

    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue overflow");

endmodule

`default_nettype wire

// ----- rtl/hsv2rgb_back.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB back end
// Forms chroma, ramp and offset from a classified word, routes them to the
// three channels and scales each channel to eight bits.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_back (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_vld,
    input  hsv2rgb_pkg::t_item i_item,
    output logic              o_valid,
    output logic [7:0]        o_red,
    output logic [7:0]        o_green,
    output logic [7:0]        o_blue
);
    import hsv2rgb_pkg::*;

    localparam int SCALED_W = 20;
    localparam int MUL_W    = 29;
    localparam int PROD_W   = SCALED_W + MUL_W;
    localparam int OUT_LSB  = 40;

    // Channel = floor(x * 17 / 40000), done as x * 17 * ceil(2^40 / 40000) >> 40.
    localparam logic [63:0]       RECIP_WIDE = ((64'd1 << OUT_LSB) + 64'd39999) / 64'd40000;
    localparam logic [63:0]       SCALE_WIDE = RECIP_WIDE * 64'd17;
    localparam logic [MUL_W-1:0]  SCALE_MUL  = SCALE_WIDE[MUL_W-1:0];
    localparam logic [SCALED_W-1:0] MAX_SCALED = SCALED_W'(600000);

    logic                r_b1_vld, r_b2_vld, r_b3_vld, r_b4_vld;
    logic [13:0]         r_b1_vs;
    logic [PCT_W-1:0]    r_b1_val;
    logic [FACTOR_W-1:0] r_b1_factor;
    t_sextant            r_b1_sxt, r_b2_sxt;
    logic [SCALED_W-1:0] r_b2_chroma, r_b2_ramp, r_b2_full;
    logic [SCALED_W-1:0] r_b3_red, r_b3_green, r_b3_blue;
    logic [PROD_W-1:0]   r_b4_red, r_b4_green, r_b4_blue;

    logic [SCALED_W-1:0] n_offset;
    logic [SCALED_W-1:0] n_part_r, n_part_g, n_part_b;

    always_comb begin
        n_offset = r_b2_full - r_b2_chroma;
        case (r_b2_sxt)
            SXT_RED_YELLOW: begin
                n_part_r = r_b2_chroma;
                n_part_g = r_b2_ramp;
                n_part_b = '0;
            end
            SXT_YELLOW_GREEN: begin
                n_part_r = r_b2_ramp;
                n_part_g = r_b2_chroma;
                n_part_b = '0;
            end
            SXT_GREEN_CYAN: begin
                n_part_r = '0;
                n_part_g = r_b2_chroma;
                n_part_b = r_b2_ramp;
            end
            SXT_CYAN_BLUE: begin
                n_part_r = '0;
                n_part_g = r_b2_ramp;
                n_part_b = r_b2_chroma;
            end
            SXT_BLUE_MAGENTA: begin
                n_part_r = r_b2_ramp;
                n_part_g = '0;
                n_part_b = r_b2_chroma;
            end
            default: begin
                n_part_r = r_b2_chroma;
                n_part_g = '0;
                n_part_b = r_b2_ramp;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld <= 1'b0;
            r_b2_vld <= 1'b0;
            r_b3_vld <= 1'b0;
            r_b4_vld <= 1'b0;
        end else begin
            r_b1_vld <= i_vld;
            r_b2_vld <= r_b1_vld;
            r_b3_vld <= r_b2_vld;
            r_b4_vld <= r_b3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b1_vs     <= 14'(i_item.val) * 14'(i_item.sat);
        r_b1_val    <= i_item.val;
        r_b1_factor <= i_item.factor;
        r_b1_sxt    <= i_item.sextant;

        r_b2_chroma <= SCALED_W'(r_b1_vs) * SCALED_W'(60);
        r_b2_ramp   <= SCALED_W'(r_b1_vs) * SCALED_W'(r_b1_factor);
        r_b2_full   <= SCALED_W'(r_b1_val) * SCALED_W'(6000);
        r_b2_sxt    <= r_b1_sxt;

        r_b3_red    <= n_part_r + n_offset;
        r_b3_green  <= n_part_g + n_offset;
        r_b3_blue   <= n_part_b + n_offset;

        r_b4_red    <= PROD_W'(r_b3_red) * PROD_W'(SCALE_MUL);
        r_b4_green  <= PROD_W'(r_b3_green) * PROD_W'(SCALE_MUL);
        r_b4_blue   <= PROD_W'(r_b3_blue) * PROD_W'(SCALE_MUL);
    end

    assign o_valid = r_b4_vld;
    assign o_red   = r_b4_red[OUT_LSB +: 8];
    assign o_green = r_b4_green[OUT_LSB +: 8];
    assign o_blue  = r_b4_blue[OUT_LSB +: 8];

    a_scaled_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b3_vld |-> (r_b3_red <= MAX_SCALED && r_b3_green <= MAX_SCALED
                      && r_b3_blue <= MAX_SCALED))
        else $error("channel sum exceeds full scale");

    a_valid_origin : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_vld, 4))
        else $error("result strobe without a dequeued word");

    a_full_offset : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b2_vld |-> (r_b2_chroma <= r_b2_full))
        else $error("chroma exceeds value scale");

endmodule

`default_nettype wire

// ----- rtl/hsv_to_rgb_converter.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Converts a signed hue in degrees and a saturation and value in percent
// into 8-bit red, green and blue.
//
//   Channel   Ports                                   Handshake
//   input     i_hue, i_saturation, i_brightness       start && !busy
//   result    o_red, o_green, o_blue                  o_valid, one cycle
//
// One word is accepted per clock while busy is low. o_valid rises once the
// accepted word has passed five front-end stages, one queue write, one
// registered queue read and four back-end stages with their multipliers.
// i_rst_n is synchronous; it clears all valid flags and the queue.
// busy rises when the queue level leaves no room for the words still in
// the front end; the back end drains one word per cycle, so in steady
// operation busy stays low.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter #(
    parameter int HUE_WIDTH = hsv2rgb_pkg::DEFAULT_HUE_WIDTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [HUE_WIDTH-1:0]          i_hue,
    input  wire logic [hsv2rgb_pkg::PCT_W-1:0] i_saturation,
    input  wire logic [hsv2rgb_pkg::PCT_W-1:0] i_brightness,
    output logic                               o_valid,
    output logic [7:0]                         o_red,
    output logic [7:0]                         o_green,
    output logic [7:0]                         o_blue
);
    import hsv2rgb_pkg::*;

    localparam logic [QUEUE_CNT_W-1:0] BUSY_LEVEL = QUEUE_CNT_W'(QUEUE_DEPTH - FRONT_STAGES);

    logic                   w_push;
    t_item                  w_push_item;
    logic                   w_head_vld;
    t_item                  w_head_item;
    logic [QUEUE_CNT_W-1:0] w_level;

    assign busy = (w_level >= BUSY_LEVEL);

    hsv2rgb_front #(
        .HUE_WIDTH(HUE_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (start && !busy),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_push       (w_push),
        .o_item       (w_push_item)
    );

    hsv2rgb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_vld   (w_head_vld),
        .o_item  (w_head_item),
        .o_level (w_level)
    );

    hsv2rgb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_head_vld),
        .i_item  (w_head_item),
        .o_valid (o_valid),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

endmodule

`default_nettype wire

// ----- sim/hsv_to_rgb_converter_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Feeds hue, saturation and value words to the converter through the
// start/busy handshake and checks every strobed result. Expected colors come
// from an exact integer model of the conversion. The stimulus covers field
// extremes, every sextant with its edges, and a long random stream with
// idle gaps of varied length.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter_tb;

    import hsv2rgb_pkg::*;

    localparam int HUE_W       = 16;
    localparam int RANDOM_WORDS = 900;
    localparam int DRAIN_CYCLES = 30;
    localparam int CYCLE_LIMIT  = 300000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               start        = 1'b0;
    logic [HUE_W-1:0]   i_hue        = '0;
    logic [PCT_W-1:0]   i_saturation = '0;
    logic [PCT_W-1:0]   i_brightness = '0;
    logic               busy;
    logic               o_valid;
    logic [7:0]         o_red;
    logic [7:0]         o_green;
    logic [7:0]         o_blue;

    t_rgb pending_rgb[$];
    int   words_sent    = 0;
    int   colors_checked = 0;
    int   error_count   = 0;
    int   cycle_count   = 0;
    bit   burst_mode    = 1'b0;

    hsv_to_rgb_converter #(
        .HUE_WIDTH(HUE_W)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_hue(i_hue),
        .i_saturation(i_saturation),
        .i_brightness(i_brightness),
        .o_valid(o_valid),
        .o_red(o_red),
        .o_green(o_green),
        .o_blue(o_blue)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d colors outstanding", $time, pending_rgb.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] scale_channel(input longint scaled);
        longint level;
        level = (scaled * 255) / 600000;
        return level[7:0];
    endfunction

    function automatic t_rgb hsv_to_rgb_predict(input logic [HUE_W-1:0] hue,
                                                input logic [PCT_W-1:0] sat,
                                                input logic [PCT_W-1:0] val);
        longint   h;
        longint   s;
        longint   v;
        longint   chroma;
        longint   ramp;
        longint   offset;
        longint   hm;
        longint   ramp_dist;
        longint   r;
        longint   g;
        longint   b;
        t_sextant sext;
        t_rgb     color;
        h = longint'(signed'(hue)) % 360;
        if (h < 0) begin
            h = h + 360;
        end
        s = (sat > 100) ? 100 : sat;
        v = (val > 100) ? 100 : val;
        chroma = v * s * 60;
        hm = h % 120;
        ramp_dist = (hm >= 60) ? hm - 60 : 60 - hm;
        ramp = v * s * (60 - ramp_dist);
        offset = v * 6000 - chroma;
        sext = t_sextant'(h / 60);
        case (sext)
            SXT_RED_YELLOW: begin
                r = chroma; g = ramp;   b = 0;
            end
            SXT_YELLOW_GREEN: begin
                r = ramp;   g = chroma; b = 0;
            end
            SXT_GREEN_CYAN: begin
                r = 0;      g = chroma; b = ramp;
            end
            SXT_CYAN_BLUE: begin
                r = 0;      g = ramp;   b = chroma;
            end
            SXT_BLUE_MAGENTA: begin
                r = ramp;   g = 0;      b = chroma;
            end
            default: begin
                r = chroma; g = 0;      b = ramp;
            end
        endcase
        color.red   = scale_channel(r + offset);
        color.green = scale_channel(g + offset);
        color.blue  = scale_channel(b + offset);
        return color;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (burst_mode || roll < 50) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic send_word(input logic [HUE_W-1:0] hue,
                             input logic [PCT_W-1:0] sat,
                             input logic [PCT_W-1:0] val);
        int gap;
        gap = pick_gap();
        start        <= 1'b1;
        i_hue        <= hue;
        i_saturation <= sat;
        i_brightness <= val;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        pending_rgb.push_back(hsv_to_rgb_predict(hue, sat, val));
        words_sent++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin : check_result
        t_rgb want;
        if (i_rst_n && o_valid) begin
            if (pending_rgb.size() == 0) begin
                $display("%0t: unexpected color r=%0d g=%0d b=%0d",
                         $time, o_red, o_green, o_blue);
                error_count++;
            end else begin
                want = pending_rgb.pop_front();
                colors_checked++;
                if (o_red !== want.red) begin
                    $display("%0t: red mismatch, expected %0d, actual %0d",
                             $time, want.red, o_red);
                    error_count++;
                end
                if (o_green !== want.green) begin
                    $display("%0t: green mismatch, expected %0d, actual %0d",
                             $time, want.green, o_green);
                    error_count++;
                end
                if (o_blue !== want.blue) begin
                    $display("%0t: blue mismatch, expected %0d, actual %0d",
                             $time, want.blue, o_blue);
                    error_count++;
                end
            end
        end
    end

    task automatic test_field_extremes();
        send_word(16'h8000, 7'd100, 7'd100);
        send_word(16'h7FFF, 7'd100, 7'd100);
        send_word(16'hFFFF, 7'd127, 7'd127);
        send_word(16'hFE98, 7'd101, 7'd50);
        send_word(16'd360, 7'd0, 7'd100);
        send_word(16'd0, 7'd100, 7'd0);
        send_word(16'd0, 7'd0, 7'd0);
        send_word(16'd720, 7'd127, 7'd101);
        send_word(16'h5555, 7'h55, 7'h2A);
        send_word(16'hAAAA, 7'h2A, 7'h55);
    endtask

    task automatic test_sextants();
        int edge_hue;
        for (int k = 0; k < 6; k++) begin
            edge_hue = k * 60;
            send_word(HUE_W'(edge_hue), 7'd100, 7'd100);
            send_word(HUE_W'(edge_hue + 30), 7'd73, 7'd88);
            send_word(HUE_W'(edge_hue + 59), 7'd100, 7'd100);
        end
    endtask

    task automatic test_random_stream();
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] sat;
        logic [PCT_W-1:0] val;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 50 == 0) begin
                burst_mode = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 9) < 6) begin
                hue = HUE_W'($urandom_range(0, 65535));
            end else begin
                hue = HUE_W'(int'($urandom_range(0, 1440)) - 720);
            end
            if ($urandom_range(0, 4) == 0) begin
                sat = PCT_W'($urandom_range(95, 127));
                val = PCT_W'($urandom_range(95, 127));
            end else begin
                sat = PCT_W'($urandom_range(0, 127));
                val = PCT_W'($urandom_range(0, 127));
            end
            send_word(hue, sat, val);
        end
        burst_mode = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_field_extremes();
        test_sextants();
        test_random_stream();
        start <= 1'b0;
        while (pending_rgb.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d words and checked %0d colors over %0d cycles,", words_sent,
                 colors_checked, cycle_count);
        $display("covering hue wrap, percent clamping, all sextants and idle gaps.");
        if (error_count == 0 && pending_rgb.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
